[src/fxalu_pkg.sv]
// Shared types for the Q24.8 fixed-point ALU pipeline.
// No dependencies; imported by every module of the block.
package fxalu_pkg;

  typedef enum logic [3:0] {
    CMD_ADD     = 4'd0,
    CMD_SUB     = 4'd1,
    CMD_MUL     = 4'd2,
    CMD_DIV     = 4'd3,
    CMD_LT      = 4'd4,
    CMD_GT      = 4'd5,
    CMD_EQ      = 4'd6,
    CMD_NE      = 4'd7,
    CMD_LE      = 4'd8,
    CMD_GE      = 4'd9,
    CMD_MAX     = 4'd10,
    CMD_MIN     = 4'd11,
    CMD_INC     = 4'd12,
    CMD_DEC     = 4'd13,
    CMD_TOINT   = 4'd14,
    CMD_FROMINT = 4'd15
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_DIV_ZERO = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_e;

  // Control that rides along with every beat.
  typedef struct packed {
    cmd_e cmd;
    logic neg;   // quotient sign
    logic dz;    // divisor is zero
    logic flag;  // comparison outcome
  } ctl_t;

endpackage

[src/fixed_point_q24_8_alu_unit.sv]
// Top level of the signed fixed-point ALU: input register, decode stage,
// divider step chain and output register. Depends on fxalu_pkg and submodules.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, cmd_i, operand_a/b_i   | to block
//   out     | out_valid_o, out_stall_i, result_raw_o,        | from block
//           | compare_true_o, error_code_o                   |
//
// One beat enters per cycle while the output is not stalled; the divider chain
// yields one quotient bit per stage.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output beat freezes the whole pipeline; in_stall_o follows it.
module fixed_point_q24_8_alu_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [3:0]          cmd_i,
  input  logic signed [31:0]  operand_a_i,
  input  logic signed [31:0]  operand_b_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  result_raw_o,
  output logic                compare_true_o,
  output logic [1:0]          error_code_o
);
  import fxalu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NQ = W + F;

  logic en;

  // input register
  logic               in_v_q;
  cmd_e               cmd_q;
  logic signed [W-1:0] a_q, b_q;

  // post-decode stages, index 0 is the decode register
  logic                  v_s    [0:NQ];
  ctl_t                  ctl_s  [0:NQ];
  logic signed [W-1:0]   res_s  [0:NQ];
  logic signed [2*W-1:0] prod_s [0:NQ];
  logic [W-1:0]          rem_s  [0:NQ];
  logic [NQ-1:0]         dq_s   [0:NQ];
  logic [W-1:0]          mb_s   [0:NQ];

  ctl_t                  f_ctl;
  logic signed [W-1:0]   f_res;
  logic signed [2*W-1:0] f_prod;
  logic [NQ-1:0]         f_dq;
  logic [W-1:0]          f_mb;

  logic signed [W-1:0]   b_res;
  logic                  b_flag;
  err_e                  b_err;

  logic                  out_v_q;
  logic signed [W-1:0]   out_res_q;
  logic                  out_flag_q;
  err_e                  out_err_q;

  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      v_s[0] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      in_v_q  <= in_valid_i;
      v_s[0]  <= in_v_q;
      out_v_q <= v_s[NQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_q      <= cmd_e'(cmd_i);
      a_q        <= operand_a_i[W-1:0];
      b_q        <= operand_b_i[W-1:0];
      ctl_s[0]   <= f_ctl;
      res_s[0]   <= f_res;
      prod_s[0]  <= f_prod;
      rem_s[0]   <= '0;
      dq_s[0]    <= f_dq;
      mb_s[0]    <= f_mb;
      out_res_q  <= b_res;
      out_flag_q <= b_flag;
      out_err_q  <= b_err;
    end
  end

  fxalu_front #(.W(W), .F(F), .NQ(NQ)) u_front (
    .cmd_i  (cmd_q),
    .a_i    (a_q),
    .b_i    (b_q),
    .ctl_o  (f_ctl),
    .res_o  (f_res),
    .prod_o (f_prod),
    .dq_o   (f_dq),
    .mb_o   (f_mb)
  );

  for (genvar i = 0; i < NQ; i++) begin : g_div
    fxalu_div_stage #(.W(W), .NQ(NQ)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .v_i    (v_s[i]),
      .ctl_i  (ctl_s[i]),
      .res_i  (res_s[i]),
      .prod_i (prod_s[i]),
      .rem_i  (rem_s[i]),
      .dq_i   (dq_s[i]),
      .mb_i   (mb_s[i]),
      .v_o    (v_s[i+1]),
      .ctl_o  (ctl_s[i+1]),
      .res_o  (res_s[i+1]),
      .prod_o (prod_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .dq_o   (dq_s[i+1]),
      .mb_o   (mb_s[i+1])
    );
  end

  fxalu_back #(.W(W), .F(F), .NQ(NQ)) u_back (
    .ctl_i  (ctl_s[NQ]),
    .res_i  (res_s[NQ]),
    .prod_i (prod_s[NQ]),
    .rem_i  (rem_s[NQ]),
    .dq_i   (dq_s[NQ]),
    .mb_i   (mb_s[NQ]),
    .res_o  (b_res),
    .flag_o (b_flag),
    .err_o  (b_err)
  );

  assign out_valid_o    = out_v_q;
  assign result_raw_o   = 32'(out_res_q);
  assign compare_true_o = out_flag_q;
  assign error_code_o   = out_err_q;

endmodule

[src/fxalu_front.sv]
// Decode stage logic: simple operations, full product and divider setup.
// Depends on fxalu_pkg.
module fxalu_front #(
  parameter int W = 32,
  parameter int F = 8,
  parameter int NQ = W + F
) (
  input  fxalu_pkg::cmd_e        cmd_i,
  input  logic signed [W-1:0]    a_i,
  input  logic signed [W-1:0]    b_i,
  output fxalu_pkg::ctl_t        ctl_o,
  output logic signed [W-1:0]    res_o,
  output logic signed [2*W-1:0]  prod_o,
  output logic [NQ-1:0]          dq_o,
  output logic [W-1:0]           mb_o
);
  import fxalu_pkg::*;

  logic [W-1:0] ma;
  logic         lt, eq;

  assign lt = a_i < b_i;
  assign eq = a_i == b_i;
  assign ma = a_i[W-1] ? (W'(0) - W'(a_i)) : W'(a_i);
  assign mb_o = b_i[W-1] ? (W'(0) - W'(b_i)) : W'(b_i);
  assign dq_o = {ma, {F{1'b0}}};
  assign prod_o = (2*W)'(a_i) * (2*W)'(b_i);

  always_comb begin
    ctl_o.cmd  = cmd_i;
    ctl_o.neg  = a_i[W-1] ^ b_i[W-1];
    ctl_o.dz   = (b_i == '0);
    ctl_o.flag = 1'b0;
    res_o      = '0;
    case (cmd_i)
      CMD_ADD:     res_o = a_i + b_i;
      CMD_SUB:     res_o = a_i - b_i;
      CMD_LT:      ctl_o.flag = lt;
      CMD_GT:      ctl_o.flag = !lt && !eq;
      CMD_EQ:      ctl_o.flag = eq;
      CMD_NE:      ctl_o.flag = !eq;
      CMD_LE:      ctl_o.flag = lt || eq;
      CMD_GE:      ctl_o.flag = !lt;
      CMD_MAX:     res_o = lt ? b_i : a_i;
      CMD_MIN:     res_o = lt ? a_i : b_i;
      CMD_INC:     res_o = a_i + W'(1);
      CMD_DEC:     res_o = a_i - W'(1);
      CMD_TOINT:   res_o = a_i >>> F;
      CMD_FROMINT: res_o = a_i << F;
      default:     res_o = '0;
    endcase
  end

endmodule

[src/fxalu_div_stage.sv]
// One registered restoring-division step; other payload passes through.
// Depends on fxalu_pkg.
module fxalu_div_stage #(
  parameter int W = 32,
  parameter int NQ = 40
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   v_i,
  input  fxalu_pkg::ctl_t        ctl_i,
  input  logic signed [W-1:0]    res_i,
  input  logic signed [2*W-1:0]  prod_i,
  input  logic [W-1:0]           rem_i,
  input  logic [NQ-1:0]          dq_i,
  input  logic [W-1:0]           mb_i,
  output logic                   v_o,
  output fxalu_pkg::ctl_t        ctl_o,
  output logic signed [W-1:0]    res_o,
  output logic signed [2*W-1:0]  prod_o,
  output logic [W-1:0]           rem_o,
  output logic [NQ-1:0]          dq_o,
  output logic [W-1:0]           mb_o
);
  import fxalu_pkg::*;

  logic [W:0]   rem2, diff;
  logic         ge;
  logic [W-1:0] rem_d;
  logic [NQ-1:0] dq_d;

  assign rem2  = {rem_i, dq_i[NQ-1]};
  assign diff  = rem2 - {1'b0, mb_i};
  assign ge    = rem2 >= {1'b0, mb_i};
  assign rem_d = ge ? diff[W-1:0] : rem2[W-1:0];
  assign dq_d  = {dq_i[NQ-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_o <= 1'b0;
    end else if (en_i) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o  <= ctl_i;
      res_o  <= res_i;
      prod_o <= prod_i;
      rem_o  <= rem_d;
      dq_o   <= dq_d;
      mb_o   <= mb_i;
    end
  end

endmodule

[src/fxalu_back.sv]
// Finish logic: product scaling, quotient rounding and saturation, result mux.
// Depends on fxalu_pkg.
module fxalu_back #(
  parameter int W = 32,
  parameter int F = 8,
  parameter int NQ = W + F
) (
  input  fxalu_pkg::ctl_t        ctl_i,
  input  logic signed [W-1:0]    res_i,
  input  logic signed [2*W-1:0]  prod_i,
  input  logic [W-1:0]           rem_i,
  input  logic [NQ-1:0]          dq_i,
  input  logic [W-1:0]           mb_i,
  output logic signed [W-1:0]    res_o,
  output logic                   flag_o,
  output fxalu_pkg::err_e        err_o
);
  import fxalu_pkg::*;

  localparam int K = W - F;

  logic signed [2*W-1:0] prod_sh;
  logic [W+K-1:0]        rem_sh;
  logic                  bump;
  logic [NQ:0]           rr;
  logic                  pos_ovf, neg_ovf;
  logic [W-1:0]          hi_w, lo_w;

  assign prod_sh = prod_i >>> F;
  assign rem_sh  = {rem_i, {K{1'b0}}};
  // Round the negative quotient toward minus infinity, judged on K more quotient bits.
  assign bump    = rem_sh >= (W+K)'(mb_i);
  assign rr      = {1'b0, dq_i} + (NQ+1)'(bump);
  assign pos_ovf = (dq_i[NQ-1:W-1] != '0);
  assign neg_ovf = (rr[NQ:W-1] != '0) &&
                   !((rr[NQ:W-1] == (NQ-W+2)'(1)) && (rr[W-2:0] == '0));
  assign hi_w    = {1'b0, {(W-1){1'b1}}};
  assign lo_w    = {1'b1, {(W-1){1'b0}}};

  always_comb begin
    flag_o = ctl_i.flag;
    err_o  = ERR_NONE;
    res_o  = res_i;
    case (ctl_i.cmd)
      CMD_MUL: res_o = prod_sh[W-1:0];
      CMD_DIV: begin
        if (ctl_i.dz) begin
          res_o = '0;
          err_o = ERR_DIV_ZERO;
        end else if (ctl_i.neg) begin
          if (neg_ovf) begin
            res_o = lo_w;
            err_o = ERR_OVERFLOW;
          end else begin
            res_o = W'(0) - rr[W-1:0];
          end
        end else if (pos_ovf) begin
          res_o = hi_w;
          err_o = ERR_OVERFLOW;
        end else begin
          res_o = dq_i[W-1:0];
        end
      end
      default: res_o = res_i;
    endcase
  end

endmodule

[dv/testbench.sv]
// Self-checking regression for the Q24.8 fixed-point ALU unit.
// Depends on fxalu_pkg and fixed_point_q24_8_alu_unit; drives both channels with random gaps.
`timescale 1ns / 1ps

module testbench;
  import fxalu_pkg::*;

  typedef struct packed {
    logic signed [31:0] raw;
    logic               flag;
    logic [1:0]         err;
  } alu_res_t;

  localparam int LATENCY = 43;
  localparam int CYCLE_LIMIT = 400000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [3:0]        cmd_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic signed [31:0] result_raw_o;
  logic              compare_true_o;
  logic [1:0]        error_code_o;

  alu_res_t expected_q[$];
  int       mismatches = 0;
  int       cycles = 0;
  bit       gaps_on = 1'b1;
  bit       hold_off = 1'b0;

  fixed_point_q24_8_alu_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .operand_a_i, .operand_b_i,
    .out_valid_o, .out_stall_i, .result_raw_o, .compare_true_o, .error_code_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fixed_point_q24_8_alu_unit regression: fail");
      $finish;
    end
  end

  function automatic alu_res_t alu_predict(cmd_e op, logic signed [31:0] a,
                                           logic signed [31:0] b);
    alu_res_t r;
    logic signed [63:0] prod;
    logic [63:0] ma, mb, q, mag;
    logic neg;
    r = '0;
    case (op)
      CMD_ADD: r.raw = a + b;
      CMD_SUB: r.raw = a - b;
      CMD_MUL: begin
        prod = 64'(a) * 64'(b);
        r.raw = prod[39:8];
      end
      CMD_DIV: begin
        if (b == 0) begin
          r.err = ERR_DIV_ZERO;
        end else begin
          neg = a[31] ^ b[31];
          ma = a[31] ? -64'(a) : 64'(a);
          mb = b[31] ? -64'(b) : 64'(b);
          q = (ma << 32) / mb;
          if (neg) begin
            mag = (q + 64'hFF_FFFF) >> 24;
            if (mag > 64'h8000_0000) begin
              r.err = ERR_OVERFLOW;
              r.raw = 32'sh8000_0000;
            end else begin
              r.raw = 32'(-mag);
            end
          end else begin
            mag = q >> 24;
            if (mag > 64'h7FFF_FFFF) begin
              r.err = ERR_OVERFLOW;
              r.raw = 32'sh7FFF_FFFF;
            end else begin
              r.raw = mag[31:0];
            end
          end
        end
      end
      CMD_LT: r.flag = a < b;
      CMD_GT: r.flag = a > b;
      CMD_EQ: r.flag = a == b;
      CMD_NE: r.flag = a != b;
      CMD_LE: r.flag = a <= b;
      CMD_GE: r.flag = a >= b;
      CMD_MAX: r.raw = a > b ? a : b;
      CMD_MIN: r.raw = a < b ? a : b;
      CMD_INC: r.raw = a + 1;
      CMD_DEC: r.raw = a - 1;
      CMD_TOINT: r.raw = a >>> 8;
      default: r.raw = a << 8;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH %s: got %h want %h (cycle %0d)", what, got, want, cycles);
  endtask

  // Receiver: random stall bursts, or a long hold-off when asked.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Check every result beat against the oldest expectation.
  always @(posedge clk_i) begin
    alu_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", result_raw_o, 32'h0);
      end else begin
        want = expected_q.pop_front();
        if (result_raw_o !== want.raw) report_mismatch("result_raw", result_raw_o, want.raw);
        if (compare_true_o !== want.flag)
          report_mismatch("compare_true", 32'(compare_true_o), 32'(want.flag));
        if (error_code_o !== want.err)
          report_mismatch("error_code", 32'(error_code_o), 32'(want.err));
      end
    end
  end

  // Valid stays high after a beat; the next call replaces the payload or drops valid.
  task automatic send_op(cmd_e op, logic [31:0] a, logic [31:0] b);
    int n;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(alu_predict(op, a, b));
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1: return 32'($signed($urandom_range(0, 1024)) - 512);
      2: return $urandom() >> $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] edges[6] = '{32'h0, 32'h100, 32'hFFFF_FF00, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'hFFFF_FFFF};
    for (int c = 0; c < 16; c++) send_op(cmd_e'(c), edges[c % 6], edges[(c + 2) % 6]);
    send_op(CMD_DIV, 32'h100, 32'h0);
    send_op(CMD_DIV, 32'h7FFF_FFFF, 32'h1);
    send_op(CMD_DIV, 32'h8000_0000, 32'h1);
    send_op(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_op(CMD_MAX, 32'h1234, 32'h1234);
    send_op(CMD_TOINT, 32'hFFFF_FF01, 32'h0);
    send_op(CMD_EQ, 32'h8000_0000, 32'h8000_0000);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_op(cmd_e'($urandom_range(0, 15)), rand_operand(), rand_operand());
  endtask

  // Hold the receiver off long enough that the pipeline freezes and stalls input.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (LATENCY * 3) @(negedge clk_i);
        hold_off = 1'b0;
      end
      test_random(80);
    join
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(400);
    test_backpressure();
    gaps_on = 1'b0;
    test_random(250);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("fixed_point_q24_8_alu_unit regression: pass");
    end else begin
      $display("fixed_point_q24_8_alu_unit regression: fail");
    end
    $finish;
  end
endmodule

[filelist.f]
src/fxalu_pkg.sv
src/fxalu_front.sv
src/fxalu_div_stage.sv
src/fxalu_back.sv
src/fixed_point_q24_8_alu_unit.sv
dv/testbench.sv
